// ===== hdl/dmt_pkg.sv =====
// Shared types, codes and sizes for the device MAC table.
`timescale 1ns / 1ps

package dmt_pkg;

    localparam int MAX_DEVICES_DEF = 16;

    localparam int MAC_W   = 64;
    localparam int BYTE_W  = 8;
    localparam int FUNC_W  = 2;
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_JOIN   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_ON = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_IGNORE = 2'd3;

    localparam logic [KIND_W-1:0] KIND_REPORT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL   = 2'd2;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [BYTE_W-1:0] bri;
        logic [BYTE_W-1:0] rat;
        logic [BYTE_W-1:0] pwr;
    } entry_t;

endpackage

// ===== hdl/device_mac_table_core.sv =====
// Device MAC table: lookup, append and update of end-device entries.
//
//   channel  direction  handshake             payload
//   req      in         req_valid, req_stall  func, dev_mac, brightness, ratio, power_state
//   rsp      out        rsp_valid, rsp_stall  kind, slot, entry_mac, entry_brightness,
//                                             entry_ratio, entry_power, online_count, last
//
// One item at a time: a new item is accepted only in the idle state. Each item walks the
// entries held in order (one read and one compare per entry); on a miss the miss state
// follows, then one or two results, or none for an ignored item or a missed set or update.
// Reset clears the entry count, the state and the result valid flag; the memory needs no clearing pass.
// A stalled result holds in the output register; the next item may be
// accepted while it waits, but its own results wait for the register.
`timescale 1ns / 1ps

module device_mac_table_core #(
    parameter int MAX_DEVICES = dmt_pkg::MAX_DEVICES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [dmt_pkg::FUNC_W-1:0]    func,
    input  logic [dmt_pkg::MAC_W-1:0]     dev_mac,
    input  logic [dmt_pkg::BYTE_W-1:0]    brightness,
    input  logic [dmt_pkg::BYTE_W-1:0]    ratio,
    input  logic [dmt_pkg::BYTE_W-1:0]    power_state,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [dmt_pkg::KIND_W-1:0]    kind,
    output logic [dmt_pkg::SLOT_W-1:0]    slot,
    output logic [dmt_pkg::MAC_W-1:0]     entry_mac,
    output logic [dmt_pkg::BYTE_W-1:0]    entry_brightness,
    output logic [dmt_pkg::BYTE_W-1:0]    entry_ratio,
    output logic [dmt_pkg::BYTE_W-1:0]    entry_power,
    output logic [dmt_pkg::COUNT_W-1:0]   online_count,
    output logic                          last
);
    import dmt_pkg::*;

    localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int CNT_W = $clog2(MAX_DEVICES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_DEVICES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_MISS = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [FUNC_W-1:0] func_reg;
    entry_t            req_reg;
    logic [KIND_W-1:0] res_kind_reg, res_kind_next;
    logic [IDX_W-1:0]  res_slot_reg, res_slot_next;
    entry_t            res_reg, res_next;
    logic              res_two_reg, res_two_next;

    logic              rsp_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [SLOT_W-1:0] slot_reg;
    entry_t            out_reg;
    logic [COUNT_W-1:0] count_reg;
    logic              last_reg;

    logic              accept;
    logic              out_free;
    logic              load_out;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    entry_t            ram_wdata;
    entry_t            rd_entry;
    logic [CNT_W-1:0]  idx_ext;
    logic [IDX_W+SLOT_W-1:0]  slot_wide;
    logic [CNT_W+COUNT_W-1:0] count_wide;

    dmt_entry_ram #(
        .DEPTH (MAX_DEVICES),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (state_reg == ST_RD),
        .raddr (idx_reg),
        .rdata (rd_entry)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign load_out  = (state_reg == ST_EMIT) && out_free;
    assign idx_ext   = CNT_W'(idx_reg);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        total_next    = total_reg;
        res_kind_next = res_kind_reg;
        res_slot_next = res_slot_reg;
        res_next      = res_reg;
        res_two_next  = res_two_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = rd_entry;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (accept && func != FUNC_IGNORE)
                begin
                    state_next = (total_reg == '0) ? ST_MISS : ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (rd_entry.mac == req_reg.mac)
                begin
                    state_next    = ST_EMIT;
                    res_slot_next = idx_reg;
                    res_two_next  = 1'b0;
                    if (func_reg == FUNC_JOIN)
                    begin
                        res_kind_next = KIND_ACK;
                        res_next      = rd_entry;
                    end
                    else
                    begin
                        res_kind_next = KIND_REPORT;
                        ram_we        = 1'b1;
                        ram_wdata.pwr = req_reg.pwr;
                        if (func_reg == FUNC_UPDATE)
                        begin
                            ram_wdata.bri = req_reg.bri;
                            ram_wdata.rat = req_reg.rat;
                        end
                        res_next = ram_wdata;
                    end
                end
                else if (idx_ext + 1'b1 == total_reg)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_MISS:
            begin
                if (func_reg != FUNC_JOIN)
                begin
                    state_next = ST_IDLE;
                end
                else if (total_reg == CNT_FULL)
                begin
                    state_next    = ST_EMIT;
                    res_kind_next = KIND_FULL;
                    res_slot_next = '0;
                    res_next      = '0;
                    res_two_next  = 1'b0;
                end
                else
                begin
                    state_next    = ST_EMIT;
                    ram_we        = 1'b1;
                    ram_waddr     = total_reg[IDX_W-1:0];
                    ram_wdata     = req_reg;
                    total_next    = total_reg + 1'b1;
                    res_kind_next = KIND_REPORT;
                    res_slot_next = total_reg[IDX_W-1:0];
                    res_next      = req_reg;
                    res_two_next  = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (res_two_reg)
                    begin
                        res_two_next  = 1'b0;
                        res_kind_next = KIND_ACK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        res_kind_reg <= res_kind_next;
        res_slot_reg <= res_slot_next;
        res_reg      <= res_next;
        res_two_reg  <= res_two_next;
        if (accept)
        begin
            func_reg    <= func;
            req_reg.mac <= dev_mac;
            req_reg.bri <= brightness;
            req_reg.rat <= ratio;
            req_reg.pwr <= power_state;
        end
    end

    assign slot_wide  = {{SLOT_W{1'b0}}, res_slot_reg};
    assign count_wide = {{COUNT_W{1'b0}}, total_reg};

    // result mac is always the item's mac: a hit matches it exactly
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            kind_reg    <= res_kind_reg;
            slot_reg    <= slot_wide[SLOT_W-1:0];
            out_reg.mac <= req_reg.mac;
            out_reg.bri <= res_reg.bri;
            out_reg.rat <= res_reg.rat;
            out_reg.pwr <= res_reg.pwr;
            count_reg   <= count_wide[COUNT_W-1:0];
            last_reg    <= !res_two_reg;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign kind             = kind_reg;
    assign slot             = slot_reg;
    assign entry_mac        = out_reg.mac;
    assign entry_brightness = out_reg.bri;
    assign entry_ratio      = out_reg.rat;
    assign entry_power      = out_reg.pwr;
    assign online_count     = count_reg;
    assign last             = last_reg;

endmodule

// ===== hdl/dmt_entry_ram.sv =====
// Entry memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module dmt_entry_ram #(
    parameter int DEPTH = dmt_pkg::MAX_DEVICES_DEF,
    parameter int AW    = 4
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  dmt_pkg::entry_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output dmt_pkg::entry_t rdata
);
    import dmt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/dmt_checker.sv =====
// Port-level checks for the device MAC table, bound to the top level.
`timescale 1ns / 1ps

module dmt_checker #(
    parameter int MAX_DEVICES = dmt_pkg::MAX_DEVICES_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_stall,
    input logic [dmt_pkg::KIND_W-1:0]  kind,
    input logic [dmt_pkg::SLOT_W-1:0]  slot,
    input logic [dmt_pkg::MAC_W-1:0]   entry_mac,
    input logic [dmt_pkg::COUNT_W-1:0] online_count,
    input logic                        last
);
    import dmt_pkg::*;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(MAX_DEVICES);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(kind) && $stable(entry_mac)
            && $stable(slot) && $stable(last))
        else $error("stalled result changed");

    a_first_is_report: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> kind == KIND_REPORT)
        else $error("non-final result is not an entry report");

    a_ack_follows: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall && !last |=> rsp_valid && kind == KIND_ACK && last
            && $stable(slot) && $stable(entry_mac) && $stable(online_count))
        else $error("join acknowledge did not follow new entry report");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && kind == KIND_FULL |-> last && online_count == FULL_COUNT && slot == '0)
        else $error("table-full result with wrong count or slot");

endmodule

bind device_mac_table_core dmt_checker #(
    .MAX_DEVICES (MAX_DEVICES)
) u_dmt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .kind         (kind),
    .slot         (slot),
    .entry_mac    (entry_mac),
    .online_count (online_count),
    .last         (last)
);
